// ===== hw/rtl/bdq_pkg.sv =====
// Shared types and codes for the bounded array deque.
// Word structs for both channels, op and status codes, cell commands.
// No dependencies.
`timescale 1ns / 1ps

package bdq_pkg;

    // Default number of storage cells
    localparam int DEPTH_DEF = 8;

    // Field widths fixed by the channel format
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 3;
    localparam int COUNT_W = 4;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ       = 3'd4,
        OP_WRITE      = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_INDEX = 2'd3
    } status_t;

    // What every cell does with its word
    typedef enum logic [1:0] {
        ACT_HOLD = 2'd0,
        ACT_UP   = 2'd1,   // take the lower neighbor's word
        ACT_DOWN = 2'd2,   // take the upper neighbor's word
        ACT_LOAD = 2'd3    // selected cell takes the new word
    } cell_act_t;

    typedef struct packed {
        op_t                       op;
        logic signed [WORD_W-1:0]  value;
        logic [INDEX_W-1:0]        index;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  read_word;
        logic [COUNT_W-1:0]        count;
        status_t                   status;
    } rsp_t;

    // Broadcast to the whole cell chain
    typedef struct packed {
        cell_act_t                 act;
        logic signed [WORD_W-1:0]  value;
    } cell_cmd_t;

endpackage

// ===== hw/rtl/bounded_array_deque.sv =====
// Bounded array deque: one row of storage cells plus a count controller.
//
// Usage:
//   Request channel req / req_valid / req_stall carries one word per op:
//   push front, push back, pop front, pop back, indexed read, indexed write.
//   Response channel rsp / rsp_valid / rsp_stall returns one word per
//   request: the word read (reads only, else zero), the element count after
//   the op and a status (ok, full, empty, bad index).
//   A request is executed in the cycle it is accepted; the whole cell row
//   shifts in that same cycle, so a push or pop at the front costs no more
//   than one at the back. The response comes from the output register in the
//   next cycle. Throughput is one request per cycle while no response is held
//   back, set by the single count register that every op reads and updates.
//   When the receiver stalls, the response register holds and req_stall is
//   raised, so at most one response is held back; the request side resumes
//   in the cycle the response is taken.
//   Reset empties the deque (count zero, no response pending). Stored words
//   are not cleared; they are never visible before being written.
// Depends on bdq_pkg, bdq_ctrl, bdq_cell.
`timescale 1ns / 1ps

module bounded_array_deque
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  req_t  req,
    output logic  rsp_valid,
    input  logic  rsp_stall,
    output rsp_t  rsp
);

    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int RD_N   = (DEPTH < (1 << INDEX_W)) ? DEPTH : (1 << INDEX_W);

    logic                      accept;
    cell_cmd_t                 cmd;
    logic [IDX_W-1:0]          sel;
    logic [COUNT_W-1:0]        res_count;
    status_t                   res_status;
    logic                      rd_hit;
    logic signed [WORD_W-1:0]  cell_data [DEPTH];
    logic signed [WORD_W-1:0]  rd_word;
    rsp_t                      rsp_reg;
    rsp_t                      rsp_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;

    // Take a new word unless a response is held back
    assign req_stall = rsp_valid_reg & rsp_stall;
    assign accept    = req_valid & ~req_stall;

    bdq_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req        (req),
        .cmd        (cmd),
        .sel        (sel),
        .res_count  (res_count),
        .res_status (res_status),
        .rd_hit     (rd_hit)
    );

    // Cell row: cell 0 takes the pushed word on a front push,
    // the top cell keeps its own word on a front pop
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [WORD_W-1:0] lower;
        logic signed [WORD_W-1:0] upper;

        if (i == 0)
        begin : g_first
            assign lower = cmd.value;
        end
        else
        begin : g_mid_lo
            assign lower = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign upper = cell_data[i];
        end
        else
        begin : g_mid_hi
            assign upper = cell_data[i+1];
        end

        bdq_cell #(
            .IDX_W (IDX_W),
            .POS   (i)
        ) u_cell (
            .clk   (clk),
            .cmd   (cmd),
            .sel   (sel),
            .lower (lower),
            .upper (upper),
            .data  (cell_data[i])
        );
    end

    // Read select over the cells an index can reach
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < RD_N; i++)
        begin
            if (rd_hit && req.index == INDEX_W'(i))
            begin
                rd_word = cell_data[i];
            end
        end
    end

    // Response register
    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_next.read_word = rd_word;
            rsp_next.count     = res_count;
            rsp_next.status    = res_status;
            rsp_valid_next     = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Every accepted word produces a response next cycle
    a_accept_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted word produced no response");

endmodule

// ===== hw/rtl/bdq_cell.sv =====
// One storage cell of the deque chain.
// Holds a single word and takes it from a neighbor or the command bus.
// Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_cell
    import bdq_pkg::*;
#(
    parameter int IDX_W = 3,
    parameter int POS   = 0
)
(
    input  logic                      clk,
    input  cell_cmd_t                 cmd,
    input  logic [IDX_W-1:0]          sel,
    input  logic signed [WORD_W-1:0]  lower,
    input  logic signed [WORD_W-1:0]  upper,
    output logic signed [WORD_W-1:0]  data
);

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;

    // Next word by command
    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.act)
            ACT_HOLD: data_next = data_reg;
            ACT_UP:   data_next = lower;
            ACT_DOWN: data_next = upper;
            ACT_LOAD:
            begin
                if (sel == IDX_W'(POS))
                begin
                    data_next = cmd.value;
                end
            end
            default:  data_next = data_reg;
        endcase
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== hw/rtl/bdq_ctrl.sv =====
// Deque control: element count, op decode, status and cell commands.
// Drives the cell chain; result fields except the read word.
// Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_ctrl
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  req_t                req,
    output cell_cmd_t           cmd,
    output logic [IDX_W-1:0]    sel,
    output logic [COUNT_W-1:0]  res_count,
    output status_t             res_status,
    output logic                rd_hit
);

    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_after;
    cell_act_t        act;
    logic             full;
    logic             empty;
    logic             idx_bad;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign idx_bad = (CMP_W'(req.index) >= CMP_W'(count_reg));

    // Op decode
    always_comb
    begin
        act         = ACT_HOLD;
        sel         = '0;
        res_status  = ST_OK;
        count_after = count_reg;
        rd_hit      = 1'b0;
        unique case (req.op)
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    act         = ACT_UP;
                    count_after = count_reg + 1'b1;
                end
            end
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    act         = ACT_LOAD;
                    sel         = IDX_W'(count_reg);
                    count_after = count_reg + 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    act         = ACT_DOWN;
                    count_after = count_reg - 1'b1;
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    count_after = count_reg - 1'b1;
                end
            end
            OP_READ:
            begin
                if (idx_bad)
                begin
                    res_status = ST_INDEX;
                end
                else
                begin
                    rd_hit = 1'b1;
                end
            end
            OP_WRITE:
            begin
                if (idx_bad)
                begin
                    res_status = ST_INDEX;
                end
                else
                begin
                    act = ACT_LOAD;
                    sel = IDX_W'(req.index);
                end
            end
            default: ;   // unused op codes do nothing
        endcase
    end

    // Cells and count move only on an accepted word
    always_comb
    begin
        cmd.value  = req.value;
        cmd.act    = accept ? act : ACT_HOLD;
        count_next = accept ? count_after : count_reg;
    end

    assign res_count = COUNT_W'(count_after);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Count never exceeds capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("deque count above capacity");

    // Refused word leaves the count alone
    a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_status != ST_OK) |=> $stable(count_reg))
        else $error("refused word changed the count");

    // Successful push grows the count by one
    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_status == ST_OK
            && (req.op == OP_PUSH_FRONT || req.op == OP_PUSH_BACK))
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not grow the count");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the bounded array deque (bounded_array_deque).
// Mirrors the deque in a scoreboard class and checks every response word.
// Depends on bdq_pkg and the RTL of bounded_array_deque.
`timescale 1ns / 1ps

module tb_top;
    import bdq_pkg::*;

    localparam int DEPTH         = DEPTH_DEF;
    localparam int RANDOM_WORDS  = 750;
    localparam int MAX_GAP       = 5;
    localparam int PRESSURE_HOLD = 80;
    localparam int IDLE_LIMIT    = 1000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int REPORT_LIMIT  = 10;

    // Op codes the block ignores
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

    // Mirror of the deque contents plus the queue of responses still owed
    class deque_mirror;
        logic signed [WORD_W-1:0] slots [DEPTH];
        int   fill;
        rsp_t owed_rsp [$];
        int   mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        // Apply one accepted request and queue the response it must give
        function void note_request(req_t w);
            rsp_t r;
            r.read_word = '0;
            r.status    = ST_OK;
            case (w.op)
                OP_PUSH_FRONT:
                    if (fill >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        for (int k = fill; k > 0; k--)
                            slots[k] = slots[k-1];
                        slots[0] = w.value;
                        fill++;
                    end
                OP_PUSH_BACK:
                    if (fill >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        slots[fill] = w.value;
                        fill++;
                    end
                OP_POP_FRONT:
                    if (fill == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        // only valid entries move down
                        for (int k = 0; k + 1 < fill; k++)
                            slots[k] = slots[k+1];
                        fill--;
                    end
                OP_POP_BACK:
                    if (fill == 0)
                        r.status = ST_EMPTY;
                    else
                        fill--;
                OP_READ:
                    if (int'(w.index) >= fill)
                        r.status = ST_INDEX;
                    else
                        r.read_word = slots[w.index];
                OP_WRITE:
                    if (int'(w.index) >= fill)
                        r.status = ST_INDEX;
                    else
                        slots[w.index] = w.value;
                default: ;  // spare codes: no change
            endcase
            r.count = COUNT_W'(fill);
            owed_rsp = {owed_rsp, r};
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t mismatch: %s", $time, what);
        endfunction

        // Compare one accepted response with the oldest owed one
        function void check_response(rsp_t got);
            rsp_t want;
            if (owed_rsp.size() == 0)
            begin
                flag($sformatf("unexpected word word=%0d count=%0d status=%0d",
                               got.read_word, got.count, got.status));
                return;
            end
            want = owed_rsp[0];
            owed_rsp.delete(0);
            if (got.read_word !== want.read_word)
                flag($sformatf("read_word exp %0d got %0d", want.read_word, got.read_word));
            if (got.count !== want.count)
                flag($sformatf("count exp %0d got %0d", want.count, got.count));
            if (got.status !== want.status)
                flag($sformatf("status exp %0d got %0d", want.status, got.status));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    deque_mirror mirror = new();
    bit quiet;          // no idling on either side while set
    int idle_cycles = 0;

    bounded_array_deque #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    function automatic req_t make_word(logic [2:0] code, logic signed [WORD_W-1:0] v,
                                       logic [INDEX_W-1:0] idx);
        req_t w;
        w.op    = op_t'(code);
        w.value = v;
        w.index = idx;
        return w;
    endfunction

    // Random request; filling biases toward pushes, else toward pops
    function automatic req_t random_word(bit filling, int fill);
        int pick;
        logic [2:0] code;
        logic signed [WORD_W-1:0] v;
        logic [INDEX_W-1:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            code = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
        else if (pick < 62)
            code = filling ? ($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK)
                           : ($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK);
        else if (pick < 77)
            code = filling ? ($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK)
                           : ($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK);
        else if (pick < 89)
            code = OP_READ;
        else
            code = OP_WRITE;
        case ($urandom_range(0, 9))
            0:       v = WORD_MAX;
            1:       v = WORD_MIN;
            2:       v = $urandom_range(0, 1) ? '0 : '1;
            default: v = $urandom;
        endcase
        if (fill > 0 && $urandom_range(0, 9) < 8)
            idx = INDEX_W'($urandom_range(0, fill - 1));
        else
            idx = INDEX_W'($urandom_range(0, DEPTH - 1));
        return make_word(code, v, idx);
    endfunction

    // Offer one word after a random gap and hold it until accepted
    task automatic send_word(req_t w);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        mirror.note_request(w);
    endtask

    // Stimulus and end of run
    initial
    begin
        bit filling;
        int phase_left;
        clk       = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_stall = 1'b0;
        quiet     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty refusals, extremes, fill to full, full refusals
        send_word(make_word(OP_POP_FRONT, '0, 3'd0));
        send_word(make_word(OP_POP_BACK, '1, 3'd7));
        send_word(make_word(OP_READ, '0, 3'd0));
        send_word(make_word(OP_WRITE, WORD_MAX, 3'd7));
        send_word(make_word(OP_PUSH_BACK, WORD_MAX, 3'd0));
        send_word(make_word(OP_PUSH_FRONT, WORD_MIN, 3'd7));
        send_word(make_word(OP_PUSH_BACK, '0, 3'd0));
        send_word(make_word(OP_PUSH_FRONT, '1, 3'd0));
        send_word(make_word(OP_PUSH_BACK, 32'sh5555_5555, 3'd2));
        send_word(make_word(OP_PUSH_FRONT, 32'shAAAA_AAAA, 3'd5));
        send_word(make_word(OP_PUSH_BACK, 32'sd1, 3'd0));
        send_word(make_word(OP_PUSH_FRONT, 32'sd2, 3'd0));
        send_word(make_word(OP_PUSH_FRONT, 32'sd3, 3'd0));
        send_word(make_word(OP_PUSH_BACK, 32'sd4, 3'd0));
        send_word(make_word(OP_READ, '0, 3'd7));
        send_word(make_word(OP_WRITE, 32'sh1234_5678, 3'd7));
        send_word(make_word(OP_READ, '0, 3'd7));
        send_word(make_word(OP_READ, '1, 3'd0));
        send_word(make_word(OP_SPARE_LO, WORD_MAX, 3'd3));
        // pop at the front while full
        send_word(make_word(OP_POP_FRONT, '0, 3'd0));
        send_word(make_word(OP_READ, '0, 3'd7));
        send_word(make_word(OP_WRITE, WORD_MIN, 3'd0));
        send_word(make_word(OP_POP_BACK, '0, 3'd0));
        send_word(make_word(OP_SPARE_HI, $urandom, 3'd5));
        send_word(make_word(OP_READ, '0, 3'd6));

        // Random: alternate fill and drain phases so full and empty recur
        filling    = 1'b1;
        phase_left = $urandom_range(10, 40);
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            quiet = (n >= 300 && n < 380);
            if (phase_left == 0)
            begin
                filling    = !filling;
                phase_left = $urandom_range(10, 40);
            end
            phase_left--;
            send_word(random_word(filling, mirror.fill));
        end
        req_valid <= 1'b0;

        while (mirror.owed_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        mirror.mismatches += mirror.owed_rsp.size();
        if (mirror.mismatches == 0)
            $display("[bounded_array_deque] OK");
        else
            $display("[bounded_array_deque] ERROR");
        $finish;
    end

    // Response side: random stall per word, two long holds to back up the input
    initial
    begin
        int hold;
        int taken;
        taken = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (taken == 200 || taken == 550)
                hold = PRESSURE_HOLD;
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (rsp_valid !== 1'b1);
            mirror.check_response(rsp);
            taken++;
        end
    end

    // Watchdog: too many cycles without any word moving
    always @(posedge clk)
    begin
        if ((req_valid === 1'b1 && req_stall === 1'b0) ||
            (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[bounded_array_deque] ERROR");
            $finish;
        end
    end

endmodule
